### rtl/xtea_pkg.sv
// Package for the XTEA block cipher: shared constants, register indexes and the mixing function.
// It has no dependencies. The top level xtea_block_cipher imports it.
package xtea_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;
    localparam int          KEY_WORDS  = 4;
    localparam int          CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD0 = 3'd0,
        REG_KEY_WORD1 = 3'd1,
        REG_KEY_WORD2 = 3'd2,
        REG_KEY_WORD3 = 3'd3
    } cfg_reg_t;

    typedef logic [31:0] word_t;

    function automatic word_t mix_word(input word_t v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

### rtl/xtea_block_cipher.sv
// XTEA block cipher with a fully unrolled pipeline of one half-round per stage.
// It depends on xtea_pkg for the delta constant, the register indexes and the mixing function.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------
//  in      | in_valid / in_ready   | cmd, in_word0, in_word1
//  out     | out_valid / out_ready | out_word0, out_word1
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request enters per cycle unless the output stalls; each result passes through all 2*ROUNDS stage registers.
// Each of the 2*ROUNDS stages holds one half-round: one mixing add, one key add and one update.
// The last stage register drives the output; a stalled output freezes the whole pipeline.
// Reset clears the stage valid bits and the key words. cfg_ready is always high; writes to key indexes are registered.
module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int ROUNDS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [31:0]          in_word0,
    input  logic [31:0]          in_word1,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_word0,
    output logic [31:0]          out_word1,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int STAGES = 2 * ROUNDS;

    word_t              key_reg [KEY_WORDS];
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    logic               cmd_reg   [STAGES];
    word_t              word0_reg [STAGES];
    word_t              word1_reg [STAGES];
    logic               cmd_in    [STAGES];
    word_t              word0_in  [STAGES];
    word_t              word1_in  [STAGES];
    word_t              word0_next[STAGES];
    word_t              word1_next[STAGES];
    logic               advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign advance    = !valid_reg[STAGES-1] || out_ready;
    assign in_ready   = advance;
    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign cmd_in[0]   = cmd;
    assign word0_in[0] = in_word0;
    assign word1_in[0] = in_word1;

    for (genvar h = 0; h < STAGES; h++)
    begin : g_stage
        localparam int          RND     = h / 2;
        localparam logic        HALF    = 1'((h % 2) != 0);
        localparam logic [63:0] SUM_E_W = 64'(XTEA_DELTA) * 64'(RND + h % 2);
        localparam logic [63:0] SUM_D_W = 64'(XTEA_DELTA) * 64'(ROUNDS - RND - h % 2);
        localparam logic [31:0] SUM_E   = SUM_E_W[31:0];
        localparam logic [31:0] SUM_D   = SUM_D_W[31:0];
        localparam logic [1:0]  IDX_E   = HALF ? SUM_E[12:11] : SUM_E[1:0];
        localparam logic [1:0]  IDX_D   = HALF ? SUM_D[1:0] : SUM_D[12:11];

        logic  upd_a;
        word_t src;
        word_t tgt;
        word_t key_sum;
        word_t term;
        word_t upd;

        if (h > 0)
        begin : g_link
            assign cmd_in[h]   = cmd_reg[h-1];
            assign word0_in[h] = word0_reg[h-1];
            assign word1_in[h] = word1_reg[h-1];
        end

        always_comb
        begin
            upd_a   = ~(cmd_in[h] ^ HALF);
            src     = upd_a ? word1_in[h] : word0_in[h];
            tgt     = upd_a ? word0_in[h] : word1_in[h];
            key_sum = cmd_in[h] ? (SUM_D + key_reg[IDX_D]) : (SUM_E + key_reg[IDX_E]);
            term    = mix_word(src) ^ key_sum;
            upd     = cmd_in[h] ? (tgt - term) : (tgt + term);
            word0_next[h] = upd_a ? upd : word0_in[h];
            word1_next[h] = upd_a ? word1_in[h] : upd;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                cmd_reg[h]   <= cmd_in[h];
                word0_reg[h] <= word0_next[h];
                word1_reg[h] <= word1_next[h];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_word0 = word0_reg[STAGES-1];
    assign out_word1 = word1_reg[STAGES-1];

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("Accepted request did not enter the first stage.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("Stage valid bits changed during a stall.");

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (valid_reg[STAGES-1:1] == $past(valid_reg[STAGES-2:0])))
        else $error("Stage valid bits did not shift on advance.");
`endif

endmodule
